@@ hw/rtl/teq_pkg.sv @@
// Shared types, codes and constants of the timer event queue.
package teq_pkg;

  localparam int KEY_W   = 16;
  localparam int DELAY_W = 32;
  localparam int CLK_W   = 48;
  localparam int FIRE_W  = 5;

  localparam logic [FIRE_W-1:0]  MAX_FIRE     = 5'd16;
  localparam logic [DELAY_W-1:0] TTN_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_CANCEL  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_FIRE,
    S_FIND,
    S_REPL,
    S_INS,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    tick_adv;
    logic    scan_inc;
    logic    remove_scan;
    logic    remove_head;
    logic    insert;
    logic    load_out;
    logic    out_fired;
    logic    out_last;
    status_t out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic scan_hit;
    logic sooner;
    logic full;
    logic fire_ok;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/timer_event_queue.sv @@
// Timer event queue: a bounded table of timer events held in expiry order.
//
// The input stream carries one request per item: in_tuser holds the action
// (set, cancel, replace if sooner, tick) and in_tdata the key and delay.
// The result stream carries one item per non-tick request and one item per
// fired event on a tick (one item if nothing fires); out_tlast marks the
// final result of a request. Every result reports time to next event,
// whether the table is empty and the event count.
// The block handles one request at a time. A set, cancel or replace scans
// the sorted table one slot a cycle for the key; inserts and removals shift
// the affected cells in parallel. A tick advances the clock, then removes
// and reports each due event from the head in turn, at most 16 events.
// Results sit in an output register, so the next request step can run
// while a result waits; when the receiver stalls, the block holds at its
// next result and takes no new request until that result is loaded into
// the output register.
// Reset empties the table and clears the millisecond clock to zero.
module timer_event_queue
  import teq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // event_key [15:0], delay_ms [47:16]
  input  logic [1:0]  in_tuser,   // action [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // fired_key [15:0], time_to_next [47:16],
                                  // queue_empty [48], event_count [53:49], zero [55:54]
  output logic [2:0]  out_tuser,  // status [1:0], fired_valid [2]
  output logic        out_tlast
);

  cmd_t    cmd;
  sts_t    sts;
  action_t in_action;

  assign in_action = action_t'(in_tuser);

  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd)
  );

  teq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_key     (in_tdata[KEY_W-1:0]),
    .in_delay   (in_tdata[KEY_W+DELAY_W-1:KEY_W]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/teq_ctrl.sv @@
// Controller state machine of the timer event queue.
module teq_ctrl
  import teq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  action_t in_action,
  input  sts_t    sts,
  output cmd_t    cmd
);

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;
  status_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= ACT_SET;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    st_nxt    = st_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.out_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          act_nxt       = in_action;
          if (in_action == ACT_TICK) begin
            cmd.tick_adv = 1'b1;
            state_nxt    = S_TICK;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_TICK: begin
        if (sts.fire_ok) begin
          cmd.remove_head = 1'b1;
          state_nxt       = S_FIRE;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_FIRE: begin
        // The fire check here already sees the table without the event
        // just removed, so it tells whether this item is the last one.
        if (sts.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_fired = 1'b1;
          cmd.out_last  = !sts.fire_ok;
          state_nxt     = sts.fire_ok ? S_TICK : S_IDLE;
        end
      end
      S_FIND: begin
        if (sts.scan_end) begin
          state_nxt = S_RESP;
          if (act_r == ACT_CANCEL) begin
            st_nxt = ST_NOT_FOUND;
          end else if (sts.full) begin
            st_nxt = ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            st_nxt     = ST_OK;
          end
        end else if (sts.scan_hit) begin
          case (act_r)
            ACT_SET: begin
              st_nxt    = ST_DUPLICATE;
              state_nxt = S_RESP;
            end
            ACT_CANCEL: begin
              cmd.remove_scan = 1'b1;
              st_nxt          = ST_OK;
              state_nxt       = S_RESP;
            end
            ACT_REPLACE: begin
              state_nxt = S_REPL;
            end
            default: begin
              st_nxt    = ST_OK;
              state_nxt = S_RESP;
            end
          endcase
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_REPL: begin
        st_nxt = ST_OK;
        if (sts.sooner) begin
          cmd.remove_scan = 1'b1;
          state_nxt       = S_INS;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/teq_dp.sv @@
// Datapath of the timer event queue: clock, sorted slot cells and result register.
module teq_dp
  import teq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [DELAY_W-1:0]    in_delay,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,
  output logic [2:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CLK_W-1:0]  clock_r;
  logic [KEY_W-1:0]  key_r [DEPTH];
  logic [CLK_W-1:0]  exp_r [DEPTH];
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     scan_r;
  logic [FIRE_W-1:0] fire_cnt_r;
  logic [KEY_W-1:0]  item_key_r;
  logic [CLK_W-1:0]  item_exp_r;
  logic [KEY_W-1:0]  fired_key_r;

  logic              out_valid_r;
  logic [55:0]       out_data_r;
  logic [2:0]        out_user_r;
  logic              out_last_r;

  logic [KEY_W-1:0]  rd_key;
  logic [CLK_W-1:0]  rd_exp;
  logic [DEPTH-1:0]  ge;
  logic [DEPTH-1:0]  ins_en;
  logic [DEPTH-1:0]  rm_en;
  logic [CLK_W-1:0]  diff;
  logic [DELAY_W-1:0] ttn;
  logic [CW+4:0]     count_ext;

  assign rd_key = key_r[scan_r[AW-1:0]];
  assign rd_exp = exp_r[scan_r[AW-1:0]];

  assign sts.scan_end = (scan_r == count_r);
  assign sts.scan_hit = (scan_r != count_r) && (rd_key == item_key_r);
  assign sts.sooner   = (item_exp_r < rd_exp);
  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.fire_ok  = (count_r != '0) && (exp_r[0] < clock_r) && (fire_cnt_r < MAX_FIRE);
  assign sts.out_free = !out_valid_r || out_tready;

  // Each cell decides locally whether it moves, takes the new event or holds.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i]     = (CW'(i) >= count_r) || (exp_r[i] > item_exp_r);
      ins_en[i] = (CW'(i) <= count_r) && ge[i];
      rm_en[i]  = cmd.remove_head || (cmd.remove_scan && (CW'(i) >= scan_r));
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key, next_key;
    logic [CLK_W-1:0] prev_exp, next_exp;
    logic             prev_ge;

    if (i == 0) begin : g_first
      assign prev_key = item_key_r;
      assign prev_exp = item_exp_r;
      assign prev_ge  = 1'b0;
    end else begin : g_mid
      assign prev_key = key_r[i-1];
      assign prev_exp = exp_r[i-1];
      assign prev_ge  = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = key_r[i];
      assign next_exp = exp_r[i];
    end else begin : g_body
      assign next_key = key_r[i+1];
      assign next_exp = exp_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert && ins_en[i]) begin
        key_r[i] <= prev_ge ? prev_key : item_key_r;
        exp_r[i] <= prev_ge ? prev_exp : item_exp_r;
      end else if (rm_en[i]) begin
        key_r[i] <= next_key;
        exp_r[i] <= next_exp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r    <= '0;
      count_r    <= '0;
      scan_r     <= '0;
      fire_cnt_r <= '0;
    end else begin
      if (cmd.tick_adv) begin
        clock_r <= clock_r + CLK_W'(1);
      end
      if (cmd.insert) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.remove_scan || cmd.remove_head) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load_item) begin
        scan_r     <= '0;
        fire_cnt_r <= '0;
      end else begin
        if (cmd.scan_inc) begin
          scan_r <= scan_r + CW'(1);
        end
        if (cmd.remove_head) begin
          fire_cnt_r <= fire_cnt_r + FIRE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_key_r <= in_key;
      item_exp_r <= clock_r + {{(CLK_W - DELAY_W){1'b0}}, in_delay};
    end
    if (cmd.remove_head) begin
      fired_key_r <= key_r[0];
    end
  end

  // Time to the head event, saturated to 32 bits; all ones when the table is empty, zero when the head is overdue.
  always_comb begin
    diff = exp_r[0] - clock_r;
    if (count_r == '0) begin
      ttn = TTN_ALL_ONES;
    end else if (exp_r[0] < clock_r) begin
      ttn = '0;
    end else if (diff < {{(CLK_W - DELAY_W){1'b0}}, TTN_ALL_ONES}) begin
      ttn = diff[DELAY_W-1:0];
    end else begin
      ttn = TTN_ALL_ONES;
    end
  end

  assign count_ext = {5'b0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {2'b00, count_ext[4:0], (count_r == '0), ttn,
                     cmd.out_fired ? fired_key_r : {KEY_W{1'b0}}};
      out_user_r <= {cmd.out_fired, cmd.out_status};
      out_last_r <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

@@ tb/sv/teq_tb_pkg.sv @@
// Expected-result tracking for the timer event queue testbench.
package teq_tb_pkg;
  import teq_pkg::*;

  localparam int TABLE_DEPTH = 16;

  typedef struct {
    status_t            status;
    logic               fired_valid;
    logic [KEY_W-1:0]   fired_key;
    logic               last;
    logic [DELAY_W-1:0] time_to_next;
    logic               queue_empty;
    logic [4:0]         event_count;
  } timer_result_t;

  class timer_table_tracker;
    logic [CLK_W-1:0] now_ms;
    logic [KEY_W-1:0] keys [TABLE_DEPTH];
    logic [CLK_W-1:0] expiries [TABLE_DEPTH];
    int unsigned      n_pending;
    timer_result_t    awaited[$];
    int unsigned      mismatches;
    int unsigned      action_hits [4];
    int unsigned      fired_total;
    int unsigned      max_burst;
    int unsigned      full_count;
    int unsigned      dup_count;
    int unsigned      checked_count;

    function new();
      now_ms        = '0;
      n_pending     = 0;
      mismatches    = 0;
      fired_total   = 0;
      max_burst     = 0;
      full_count    = 0;
      dup_count     = 0;
      checked_count = 0;
      foreach (action_hits[i]) action_hits[i] = 0;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function void remove_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < n_pending; i++) begin
        keys[i]     = keys[i + 1];
        expiries[i] = expiries[i + 1];
      end
      n_pending--;
    endfunction

    // Equal expiries stay in arrival order, so the new entry goes after them.
    function status_t insert(logic [KEY_W-1:0] key, logic [CLK_W-1:0] expiry);
      int unsigned pos;
      if (n_pending >= TABLE_DEPTH) return ST_FULL;
      pos = 0;
      while (pos < n_pending && expiries[pos] <= expiry) pos++;
      for (int unsigned i = n_pending; i > pos; i--) begin
        keys[i]     = keys[i - 1];
        expiries[i] = expiries[i - 1];
      end
      keys[pos]     = key;
      expiries[pos] = expiry;
      n_pending++;
      return ST_OK;
    endfunction

    function void push_result(status_t st, logic fv, logic [KEY_W-1:0] fkey, logic lst);
      timer_result_t    r;
      logic [CLK_W-1:0] diff;
      r.status       = st;
      r.fired_valid  = fv;
      r.fired_key    = fkey;
      r.last         = lst;
      r.time_to_next = TTN_ALL_ONES;
      if (n_pending > 0) begin
        if (expiries[0] < now_ms) begin
          r.time_to_next = '0;
        end else begin
          diff = expiries[0] - now_ms;
          if (diff < {16'b0, TTN_ALL_ONES}) r.time_to_next = diff[DELAY_W-1:0];
        end
      end
      r.queue_empty = (n_pending == 0);
      r.event_count = n_pending[4:0];
      awaited.push_back(r);
    endfunction

    function void apply_request(action_t act, logic [KEY_W-1:0] key,
                                logic [DELAY_W-1:0] delay);
      logic [CLK_W-1:0] expiry;
      logic [KEY_W-1:0] fkey;
      int               pos;
      int unsigned      burst;
      status_t          st;
      expiry = now_ms + delay;
      st     = ST_OK;
      action_hits[act]++;
      if (act == ACT_TICK) begin
        now_ms = now_ms + 1'b1;
        burst  = 0;
        while (burst < MAX_FIRE && n_pending > 0 && expiries[0] < now_ms) begin
          fkey = keys[0];
          remove_at(0);
          push_result(ST_OK, 1'b1, fkey, 1'b0);
          burst++;
        end
        if (burst == 0) begin
          push_result(ST_OK, 1'b0, '0, 1'b1);
        end else begin
          awaited[awaited.size() - 1].last = 1'b1;
        end
        fired_total += burst;
        if (burst > max_burst) max_burst = burst;
        return;
      end
      pos = -1;
      for (int i = 0; i < n_pending; i++)
        if (pos < 0 && keys[i] == key) pos = i;
      case (act)
        ACT_SET: begin
          st = (pos >= 0) ? ST_DUPLICATE : insert(key, expiry);
        end
        ACT_CANCEL: begin
          if (pos >= 0) remove_at(pos);
          else st = ST_NOT_FOUND;
        end
        default: begin
          if (pos < 0) begin
            st = insert(key, expiry);
          end else if (expiry < expiries[pos]) begin
            remove_at(pos);
            st = insert(key, expiry);
          end
        end
      endcase
      if (st == ST_FULL) full_count++;
      if (st == ST_DUPLICATE) dup_count++;
      push_result(st, 1'b0, '0, 1'b1);
    endfunction

    function void compare_field(string name, logic [DELAY_W-1:0] want_v,
                                logic [DELAY_W-1:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(logic [55:0] data, logic [2:0] user, logic lst);
      timer_result_t want;
      if (awaited.size() == 0) begin
        $error("result item with nothing expected: tdata 'h%0h tuser 'h%0h", data, user);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked_count++;
      compare_field("status", want.status, user[1:0]);
      compare_field("fired_valid", want.fired_valid, user[2]);
      compare_field("fired_key", want.fired_key, data[15:0]);
      compare_field("last", want.last, lst);
      compare_field("time_to_next", want.time_to_next, data[47:16]);
      compare_field("queue_empty", want.queue_empty, data[48]);
      compare_field("event_count", want.event_count, data[53:49]);
    endfunction
  endclass

endpackage

@@ tb/sv/timer_event_queue_tb.sv @@
// Testbench for the timer event queue: directed and random requests with checked results.
module timer_event_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import teq_pkg::*;
  import teq_tb_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int FLUSH_CYCLES = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = ACT_SET;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  bit tx_steady       = 1'b0;
  bit rx_steady       = 1'b0;
  bit rx_hold_request = 1'b0;

  timer_table_tracker tracker = new();

  timer_event_queue #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(input action_t act, input logic [KEY_W-1:0] key,
                              input logic [DELAY_W-1:0] delay);
    while (!tx_steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {delay, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.apply_request(act, key, delay);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    action_t            act;
    logic [KEY_W-1:0]   key;
    logic [DELAY_W-1:0] delay;
    int unsigned        r;
    r = $urandom_range(99);
    if (r < 32) act = ACT_SET;
    else if (r < 47) act = ACT_CANCEL;
    else if (r < 67) act = ACT_REPLACE;
    else act = ACT_TICK;
    // A small key pool makes duplicates and cancel hits common.
    r = $urandom_range(9);
    if ($urandom_range(99) < 30) key = 16'($urandom);
    else key = (r == 9) ? 16'hFFFF : 16'(r);
    r = $urandom_range(99);
    if (r < 55) delay = $urandom_range(6);
    else if (r < 80) delay = $urandom_range(40);
    else if (r < 92) delay = $urandom;
    else delay = TTN_ALL_ONES;
    send_request(act, key, delay);
  endtask

  // Fills the table past capacity with distinct keys, then ticks enough to fire every event it set.
  task automatic fill_and_drain_table();
    logic [KEY_W-1:0] base;
    base = 16'($urandom);
    for (int i = 0; i < TABLE_DEPTH + 1; i++)
      send_request(ACT_SET, base + 16'(i), $urandom_range(3));
    send_request(ACT_REPLACE, base + 16'($urandom_range(TABLE_DEPTH + 2)), $urandom_range(3));
    repeat (6) send_request(ACT_TICK, 16'($urandom), $urandom);
  endtask

  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tdata, out_tuser, out_tlast);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty tick, misses, saturation, duplicate, rearm rules, full table,
    // then a tick that fires the whole table at once in arrival order.
    send_request(ACT_TICK, 16'h0000, 32'h0);
    send_request(ACT_CANCEL, 16'h1234, 32'h0);
    send_request(ACT_SET, 16'hFFFF, TTN_ALL_ONES);
    send_request(ACT_SET, 16'hFFFF, 32'd5);
    send_request(ACT_REPLACE, 16'hFFFF, 32'd3);
    send_request(ACT_REPLACE, 16'hFFFF, 32'd10);
    send_request(ACT_REPLACE, 16'h0000, 32'd2);
    send_request(ACT_CANCEL, 16'hFFFF, 32'h0);
    for (int i = 1; i < TABLE_DEPTH; i++) send_request(ACT_SET, 16'(i), 32'd2);
    send_request(ACT_SET, 16'd100, 32'h0);
    send_request(ACT_REPLACE, 16'd101, 32'h0);
    repeat (3) send_request(ACT_TICK, 16'hFFFF, TTN_ALL_ONES);
    wait_for_results();

    repeat (80) send_random_request();
    wait_for_results();

    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (60) send_random_request();

    // The receiver stops for a long stretch while requests keep coming.
    rx_hold_request = 1'b1;
    repeat (50) send_random_request();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_for_results();

    repeat (3) fill_and_drain_table();
    repeat (40) send_random_request();
    wait_for_results();

    repeat (FLUSH_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d set, %0d cancel, %0d replace, %0d tick), %0d results checked.",
             tracker.action_hits[ACT_SET] + tracker.action_hits[ACT_CANCEL] +
             tracker.action_hits[ACT_REPLACE] + tracker.action_hits[ACT_TICK],
             tracker.action_hits[ACT_SET], tracker.action_hits[ACT_CANCEL],
             tracker.action_hits[ACT_REPLACE], tracker.action_hits[ACT_TICK],
             tracker.checked_count);
    $display("Fired %0d events, up to %0d on one tick; %0d full and %0d duplicate rejections.",
             tracker.fired_total, tracker.max_burst, tracker.full_count, tracker.dup_count);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/teq_pkg.sv
hw/rtl/teq_ctrl.sv
hw/rtl/teq_dp.sv
hw/rtl/timer_event_queue.sv
tb/sv/teq_tb_pkg.sv
tb/sv/timer_event_queue_tb.sv
